[hw/rtl/swss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_pkg
// Shared types and constants for the sliding window sensor statistics block.
// ----------------------------------------------------------------------------
package swss_pkg;

  localparam int Depth   = 64;
  localparam int PtrW    = $clog2(Depth);
  localparam int CntW    = $clog2(Depth + 1);
  localparam int TempW   = 15;
  localparam int PressW  = 17;
  localparam int HumidW  = 14;
  localparam int IndexW  = 8;
  localparam int SampleW = TempW + PressW + HumidW;
  localparam int TSumW   = TempW + CntW;
  localparam int PSumW   = PressW + CntW;
  localparam int HSumW   = HumidW + CntW;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_AVG   = 2'd1,
    KIND_MAX   = 2'd2,
    KIND_MIN   = 2'd3
  } kind_t;

  typedef enum logic {
    ACT_PUSH  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PressW-1:0]       press;
    logic [HumidW-1:0]       humid;
  } sample_t;

endpackage

[hw/rtl/swss_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_in_if / swss_out_if
// Valid/ready channels for samples and queries in, results out.
// ----------------------------------------------------------------------------
interface swss_in_if import swss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [TempW-1:0]  temp_in;
  logic [PressW-1:0]        press_in;
  logic [HumidW-1:0]        humid_in;
  logic [IndexW-1:0]        index;
  modport source (output valid, action, temp_in, press_in, humid_in, index, input ready);
  modport sink   (input valid, action, temp_in, press_in, humid_in, index, output ready);
endinterface

interface swss_out_if import swss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic                     valid_res;
  logic signed [TempW-1:0]  temp_out;
  logic [PressW-1:0]        press_out;
  logic [HumidW-1:0]        humid_out;
  logic                     last;
  modport source (output valid, kind, valid_res, temp_out, press_out, humid_out, last,
                  input ready);
  modport sink   (input valid, kind, valid_res, temp_out, press_out, humid_out, last,
                  output ready);
endinterface

[hw/rtl/divu_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swss_div
// Restoring divider, one quotient bit per cycle, for the window averages.
// ----------------------------------------------------------------------------
module swss_div import swss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PSumW-1:0]   dividend,
  input  logic [CntW-1:0]    divisor,
  output logic               done,
  output logic [PSumW-1:0]   quotient
);
  localparam int StepW = $clog2(PSumW + 1);

  logic [PSumW-1:0] q_r;
  logic [CntW:0]    rem_r;
  logic [StepW-1:0] step_r;
  logic             busy_r;
  logic [CntW:0]    trial;

  assign trial    = {rem_r[CntW-1:0], q_r[PSumW-1]};
  assign quotient = q_r;

  // shift in one dividend bit and subtract when it fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        step_r <= StepW'(PSumW);
      end else if (busy_r) begin
        if (trial >= {1'b0, divisor}) begin
          rem_r <= trial - {1'b0, divisor};
          q_r   <= {q_r[PSumW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[PSumW-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == StepW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/sliding_window_sensor_stats.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sensor_stats
// Ring of the last Depth sensor samples with indexed read and window stats.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : action 0 pushes a sample (no result); action 1 queries.
//           A full ring drops its oldest sample on push.
//   out_* : a query gives four transfers: indexed entry, average, maximum,
//           minimum; last marks the fourth.
// Timing: one item at a time. A push is written on its transfer cycle and
//   the next item may follow on the next cycle. A query reads the entry,
//   walks the fill_count stored samples from the single-port sample memory,
//   one per cycle, divides the three sums with a shared one-bit-per-cycle
//   divider and loads the three statistics; the input is held off from the
//   query transfer until the minimum is loaded into the output register.
//   Each result waits in the output register until taken; a stalled
//   receiver holds the sequencer at the next result load, not during the
//   walk or the divides.
// Reset: ring empty, pointers zero; the sample memory is not cleared and
//   only written entries are ever reported. No clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_sensor_stats import swss_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  swss_in_if.sink    in_ch,
  swss_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ENTRY_RD, ST_ENTRY_OUT, ST_WALK, ST_WALK_LAST,
    ST_DIV_T, ST_DIV_P, ST_DIV_H, ST_AVG_OUT, ST_MAX_OUT, ST_MIN_OUT
  } state_t;

  sample_t          mem [Depth];
  sample_t          rd_q;
  state_t           state_r;
  logic [PtrW-1:0]  oldest_r;
  logic [CntW-1:0]  fill_r;
  logic [CntW-1:0]  walk_r;
  logic             ent_ok_r;
  logic signed [TSumW-1:0] tsum_r;
  logic [PSumW-1:0] psum_r;
  logic [HSumW-1:0] hsum_r;
  sample_t          max_r, min_r;
  sample_t          avg_r;
  logic             tneg_r;
  logic             div_busy_r;

  logic             rd_en;
  logic [PtrW-1:0]  rd_addr;
  logic             wr_en;
  logic [PtrW-1:0]  wr_addr;
  logic             out_free;
  logic             out_load;
  logic             div_start;
  logic [PSumW-1:0] div_a;
  logic             div_done;
  logic [PSumW-1:0] div_q;
  logic [TSumW-1:0] tmag;

  // ring position oldest + offset
  function automatic logic [PtrW-1:0] ring_pos(logic [PtrW-1:0] base, logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = {{(CntW+1-PtrW){1'b0}}, base} + {1'b0, off};
    if (s >= (CntW+1)'(Depth)) s = s - (CntW+1)'(Depth);
    return s[PtrW-1:0];
  endfunction

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign out_load    = out_free && (state_r == ST_ENTRY_OUT || state_r == ST_AVG_OUT ||
                                    state_r == ST_MAX_OUT || state_r == ST_MIN_OUT);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign wr_en   = in_ch.valid && in_ch.ready && in_ch.action == ACT_PUSH;
  assign wr_addr = (fill_r == CntW'(Depth)) ? oldest_r : ring_pos(oldest_r, fill_r);

  // read address: entry lookup, then the window walk
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ring_pos(oldest_r, walk_r);
    if (in_ch.valid && in_ch.ready && in_ch.action == ACT_QUERY) begin
      rd_en   = 1'b1;
      rd_addr = ring_pos(oldest_r, CntW'(in_ch.index[PtrW-1:0]));
    end else if (state_r == ST_WALK || (state_r == ST_ENTRY_OUT && out_free)) begin
      rd_en = 1'b1;
    end
  end

  // sample memory, one port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= '{temp: in_ch.temp_in, press: in_ch.press_in,
                                 humid: in_ch.humid_in};
    else if (rd_en) rd_q <= mem[rd_addr];
  end

  assign tmag  = tsum_r[TSumW-1] ? TSumW'(-tsum_r) : TSumW'(tsum_r);
  assign div_a = (state_r == ST_DIV_T) ? PSumW'(tmag) :
                 (state_r == ST_DIV_P) ? psum_r : PSumW'(hsum_r);

  swss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(fill_r), .done(div_done), .quotient(div_q)
  );

  assign div_start = (state_r == ST_DIV_T || state_r == ST_DIV_P || state_r == ST_DIV_H)
                     && !div_busy_r;

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      oldest_r     <= '0;
      fill_r       <= '0;
      walk_r       <= '0;
      div_busy_r   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // load a new result when free, else drop a taken one
      if (out_load) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.action == ACT_PUSH) begin
              if (fill_r == CntW'(Depth)) oldest_r <= ring_pos(oldest_r, CntW'(1));
              else fill_r <= fill_r + 1'b1;
            end else begin
              ent_ok_r <= (CntW+IndexW)'(in_ch.index) < (CntW+IndexW)'(fill_r);
              walk_r   <= '0;
              state_r  <= ST_ENTRY_RD;
            end
          end
        end
        ST_ENTRY_RD: state_r <= ST_ENTRY_OUT;
        ST_ENTRY_OUT: begin
          if (out_free) begin
            out_ch.kind      <= KIND_ENTRY;
            out_ch.valid_res <= ent_ok_r;
            out_ch.temp_out  <= ent_ok_r ? rd_q.temp : '0;
            out_ch.press_out <= ent_ok_r ? rd_q.press : '0;
            out_ch.humid_out <= ent_ok_r ? rd_q.humid : '0;
            out_ch.last      <= 1'b0;
            tsum_r <= '0;
            psum_r <= '0;
            hsum_r <= '0;
            walk_r <= CntW'(1);
            state_r <= (fill_r == '0) ? ST_AVG_OUT :
                       (fill_r == CntW'(1)) ? ST_WALK_LAST : ST_WALK;
          end
        end
        ST_WALK, ST_WALK_LAST: begin
          // rd_q holds sample walk_r-1
          tsum_r <= tsum_r + TSumW'(rd_q.temp);
          psum_r <= psum_r + PSumW'(rd_q.press);
          hsum_r <= hsum_r + HSumW'(rd_q.humid);
          if (walk_r == CntW'(1)) begin
            max_r <= rd_q;
            min_r <= rd_q;
          end else begin
            if (rd_q.temp > max_r.temp) max_r.temp <= rd_q.temp;
            if (rd_q.temp < min_r.temp) min_r.temp <= rd_q.temp;
            if (rd_q.press > max_r.press) max_r.press <= rd_q.press;
            if (rd_q.press < min_r.press) min_r.press <= rd_q.press;
            if (rd_q.humid > max_r.humid) max_r.humid <= rd_q.humid;
            if (rd_q.humid < min_r.humid) min_r.humid <= rd_q.humid;
          end
          walk_r <= walk_r + 1'b1;
          if (state_r == ST_WALK_LAST) state_r <= ST_DIV_T;
          else if (walk_r + 1'b1 == fill_r) state_r <= ST_WALK_LAST;
        end
        ST_DIV_T, ST_DIV_P, ST_DIV_H: begin
          if (div_start) begin
            div_busy_r <= 1'b1;
            if (state_r == ST_DIV_T) tneg_r <= tsum_r[TSumW-1];
          end else if (div_done) begin
            div_busy_r <= 1'b0;
            case (state_r)
              ST_DIV_T: begin
                avg_r.temp <= tneg_r ? TempW'(-div_q) : TempW'(div_q);
                state_r    <= ST_DIV_P;
              end
              ST_DIV_P: begin
                avg_r.press <= PressW'(div_q);
                state_r     <= ST_DIV_H;
              end
              default: begin
                avg_r.humid <= HumidW'(div_q);
                state_r     <= ST_AVG_OUT;
              end
            endcase
          end
        end
        ST_AVG_OUT, ST_MAX_OUT, ST_MIN_OUT: begin
          if (out_free) begin
            out_ch.valid_res <= (fill_r != '0);
            out_ch.last      <= (state_r == ST_MIN_OUT);
            if (fill_r == '0) begin
              out_ch.temp_out  <= '0;
              out_ch.press_out <= '0;
              out_ch.humid_out <= '0;
            end
            case (state_r)
              ST_AVG_OUT: begin
                out_ch.kind <= KIND_AVG;
                if (fill_r != '0) begin
                  out_ch.temp_out  <= avg_r.temp;
                  out_ch.press_out <= avg_r.press;
                  out_ch.humid_out <= avg_r.humid;
                end
                state_r <= ST_MAX_OUT;
              end
              ST_MAX_OUT: begin
                out_ch.kind <= KIND_MAX;
                if (fill_r != '0) begin
                  out_ch.temp_out  <= max_r.temp;
                  out_ch.press_out <= max_r.press;
                  out_ch.humid_out <= max_r.humid;
                end
                state_r <= ST_MIN_OUT;
              end
              default: begin
                out_ch.kind <= KIND_MIN;
                if (fill_r != '0) begin
                  out_ch.temp_out  <= min_r.temp;
                  out_ch.press_out <= min_r.press;
                  out_ch.humid_out <= min_r.humid;
                end
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // fill count never exceeds the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(Depth)) else $error("fill count above depth");

  // no new item while a result other than the last is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready || out_ch.last) else $error("accept with result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind))
    else $error("result dropped");

endmodule
